### design/lsd_pkg.sv
package lsd_pkg;

    localparam int LENGTH_BITS      = 32;
    localparam int CHAR_BITS        = 8;
    localparam int MAGIC_MAX_LENGTH = 8;
    localparam int MAGIC_IDX_W      = (MAGIC_MAX_LENGTH > 1) ? $clog2(MAGIC_MAX_LENGTH) : 1;
    localparam int MAGIC_LEN_W      = 4;
    localparam int MAGIC_VALUE_W    = 64;
    localparam int HEADER_LEN_W     = 16;
    localparam int BIT_COUNT_W      = $clog2(LENGTH_BITS);
    localparam int KIND_W           = 3;
    localparam int CFG_INDEX_W      = 2;
    localparam int CFG_DATA_W       = 64;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [HEADER_LEN_W-1:0] HEADER_LEN_RESET = HEADER_LEN_W'(54);

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_LENGTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_VALUE   = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_MAGIC_LEN  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MAGIC_CHR  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EXT_LEN    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EXT_CHR    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DATA_LEN   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DATA_BYTE  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_MISMATCH   = 3'd6;

    // One classified beat handed from the front end to the parser.
    typedef struct packed {
        logic restart;   // first beat of a new image
        logic has_bit;   // beat carries a hidden bit
        logic bit_val;   // the hidden bit
    } lsd_entry_t;

endpackage

### design/lsb_stego_stream_decoder_unit.sv
// An accepted beat is stored in the queue; the parser pops it and registers its result on m_*.
// One byte per cycle while s_ready is high, each moving at most one hidden bit through the parser.
// A four-entry queue parts the front end from the parser; while m_ready is low it takes four more
// entries behind a waiting result before s_ready drops.
// Reset (aresetn low, synchronous) restores header_length to 54, clears the magic registers,
// empties the queue and output register, and parses the next byte as the start of an image.
module lsb_stego_stream_decoder_unit import lsd_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_image_byte,
    input  logic                   s_image_start,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [KIND_W-1:0]      m_kind,
    output logic [LENGTH_BITS-1:0] m_value,
    output logic                   m_last,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [HEADER_LEN_W-1:0]  header_length_reg;
    logic [MAGIC_LEN_W-1:0]   magic_length_reg;
    logic [MAGIC_VALUE_W-1:0] magic_value_reg;
    logic [MAGIC_LEN_W-1:0]   magic_length_sat;

    logic       push;
    logic       pop;
    logic       queue_full;
    logic       queue_empty;
    lsd_entry_t push_entry;
    lsd_entry_t pop_entry;

    // Configuration writes are always accepted, as cfg_ready is tied high. A magic length in the low
    // MAGIC_LEN_W bits above the supported maximum is clipped to the maximum; an unknown index is dropped.
    assign cfg_ready        = 1'b1;
    assign magic_length_sat = (cfg_data[MAGIC_LEN_W-1:0] > MAGIC_LEN_W'(MAGIC_MAX_LENGTH))
                              ? MAGIC_LEN_W'(MAGIC_MAX_LENGTH) : cfg_data[MAGIC_LEN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_length_reg <= HEADER_LEN_RESET;
            magic_length_reg  <= '0;
            magic_value_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_HEADER_LENGTH: header_length_reg <= cfg_data[HEADER_LEN_W-1:0];
                CFG_MAGIC_LENGTH:  magic_length_reg  <= magic_length_sat;
                CFG_MAGIC_VALUE:   magic_value_reg   <= cfg_data[MAGIC_VALUE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The front end counts off the header bytes and turns each beat after them into one
    // hidden bit. A start mark that falls inside the header still goes to the parser
    // so that it can restart.
    lsd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_image_byte  (s_image_byte),
        .s_image_start (s_image_start),
        .header_length (header_length_reg),
        .queue_full    (queue_full),
        .push          (push),
        .push_entry    (push_entry)
    );

    lsd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .full       (queue_full),
        .empty      (queue_empty)
    );

    // The parser assembles fields from the bits, checks the magic string, and
    // drives the output register. It takes one queue entry whenever the output
    // register is free or being emptied.
    lsd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .entry        (pop_entry),
        .queue_empty  (queue_empty),
        .pop          (pop),
        .magic_length (magic_length_reg),
        .magic_value  (magic_value_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_value      (m_value),
        .m_last       (m_last)
    );

endmodule

### design/lsd_front.sv
module lsd_front import lsd_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_image_byte,
    input  logic                    s_image_start,
    input  logic [HEADER_LEN_W-1:0] header_length,
    input  logic                    queue_full,
    output logic                    push,
    output lsd_entry_t              push_entry
);

    logic                    in_skip_reg, in_skip_next;
    logic [HEADER_LEN_W-1:0] skip_count_reg, skip_count_next;
    logic                    accept;
    logic                    skipping;
    logic [HEADER_LEN_W-1:0] count_now;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        in_skip_next    = in_skip_reg;
        skip_count_next = skip_count_reg;
        push            = 1'b0;
        push_entry      = '{restart: s_image_start, has_bit: 1'b0, bit_val: s_image_byte[0]};
        skipping        = s_image_start ? 1'b1 : in_skip_reg;
        count_now       = s_image_start ? '0 : skip_count_reg;
        if (accept) begin
            if (skipping && (count_now < header_length)) begin
                // Header byte: only a start mark has to reach the parser.
                in_skip_next    = 1'b1;
                skip_count_next = count_now + 1'b1;
                push            = s_image_start;
            end else begin
                in_skip_next       = 1'b0;
                skip_count_next    = count_now;
                push               = 1'b1;
                push_entry.has_bit = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_skip_reg    <= 1'b1;
            skip_count_reg <= '0;
        end else begin
            in_skip_reg    <= in_skip_next;
            skip_count_reg <= skip_count_next;
        end
    end

endmodule

### design/lsd_queue.sv
module lsd_queue import lsd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  lsd_entry_t push_entry,
    input  logic       pop,
    output lsd_entry_t pop_entry,
    output logic       full,
    output logic       empty
);

    lsd_entry_t             mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;

    assign full      = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

### design/lsd_back.sv
module lsd_back import lsd_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lsd_entry_t               entry,
    input  logic                     queue_empty,
    output logic                     pop,
    input  logic [MAGIC_LEN_W-1:0]   magic_length,
    input  logic [MAGIC_VALUE_W-1:0] magic_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [KIND_W-1:0]        m_kind,
    output logic [LENGTH_BITS-1:0]   m_value,
    output logic                     m_last
);

    localparam logic [2:0] PH_MLEN = 3'd1;
    localparam logic [2:0] PH_MCHR = 3'd2;
    localparam logic [2:0] PH_ELEN = 3'd3;
    localparam logic [2:0] PH_ECHR = 3'd4;
    localparam logic [2:0] PH_DLEN = 3'd5;
    localparam logic [2:0] PH_DATA = 3'd6;
    localparam logic [2:0] PH_DONE = 3'd7;

    logic [2:0]             phase_reg, phase_next;
    logic [BIT_COUNT_W-1:0] bit_count_reg, bit_count_next;
    logic [LENGTH_BITS-1:0] acc_reg, acc_next;
    logic [LENGTH_BITS-1:0] item_count_reg, item_count_next;
    logic [LENGTH_BITS-1:0] field_length_reg, field_length_next;
    logic                   mismatch_reg, mismatch_next;
    logic                   m_valid_reg, m_valid_next;
    logic [KIND_W-1:0]      m_kind_reg;
    logic [LENGTH_BITS-1:0] m_value_reg;
    logic                   m_last_reg;

    logic                   out_free;
    logic                   res_valid;
    logic [KIND_W-1:0]      res_kind;
    logic [LENGTH_BITS-1:0] res_value;
    logic                   res_last;
    logic [LENGTH_BITS-1:0] acc_shift;
    logic [2:0]             phase_cur;
    logic                   wide;
    logic                   complete;
    logic [LENGTH_BITS-1:0] field_value;
    logic [LENGTH_BITS-1:0] item_inc;
    logic [CHAR_BITS-1:0]   expected;

    assign out_free = !m_valid_reg || m_ready;
    assign pop      = !queue_empty && out_free;
    // Bits enter at the top, so the field ends up left-aligned at the top.
    assign acc_shift   = {entry.bit_val, acc_reg[LENGTH_BITS-1:1]};
    // Phase that the popped bit belongs to, after a start mark has been applied.
    assign phase_cur   = (pop && entry.restart) ? PH_MLEN : phase_reg;
    assign wide        = (phase_cur == PH_MLEN) || (phase_cur == PH_ELEN)
                         || (phase_cur == PH_DLEN);
    assign field_value = wide ? acc_shift
                              : {{(LENGTH_BITS-CHAR_BITS){1'b0}},
                                 acc_shift[LENGTH_BITS-1 -: CHAR_BITS]};
    assign item_inc    = item_count_reg + 1'b1;

    always_comb begin
        expected = '0;
        if (item_count_reg < LENGTH_BITS'(MAGIC_MAX_LENGTH)) begin
            expected = magic_value[item_count_reg[MAGIC_IDX_W-1:0]*CHAR_BITS +: CHAR_BITS];
        end
    end

    always_comb begin
        phase_next        = phase_reg;
        bit_count_next    = bit_count_reg;
        acc_next          = acc_reg;
        item_count_next   = item_count_reg;
        field_length_next = field_length_reg;
        mismatch_next     = mismatch_reg;
        res_valid         = 1'b0;
        res_kind          = KIND_MISMATCH;
        res_value         = '0;
        res_last          = 1'b0;
        complete          = 1'b0;
        if (pop && entry.restart) begin
            phase_next        = PH_MLEN;
            bit_count_next    = '0;
            item_count_next   = '0;
            field_length_next = '0;
            mismatch_next     = 1'b0;
        end
        if (pop && entry.has_bit && (phase_next != PH_DONE)) begin
            if (mismatch_next) begin
                phase_next = PH_DONE;
                res_valid  = 1'b1;
                res_kind   = KIND_MISMATCH;
                res_last   = 1'b1;
            end else begin
                acc_next = acc_shift;
                complete = wide ? (bit_count_next == BIT_COUNT_W'(LENGTH_BITS-1))
                                : (bit_count_next == BIT_COUNT_W'(CHAR_BITS-1));
                if (!complete) begin
                    bit_count_next = bit_count_next + 1'b1;
                end else begin
                    bit_count_next = '0;
                    res_valid      = 1'b1;
                    res_value      = field_value;
                    case (phase_next)
                        PH_MLEN: begin
                            res_kind          = KIND_MAGIC_LEN;
                            field_length_next = field_value;
                            item_count_next   = '0;
                            if (field_value != LENGTH_BITS'(magic_length)) begin
                                mismatch_next = 1'b1;
                            end else begin
                                phase_next = (field_value != '0) ? PH_MCHR : PH_ELEN;
                            end
                        end
                        PH_MCHR: begin
                            res_kind = KIND_MAGIC_CHR;
                            if (field_value[CHAR_BITS-1:0] != expected) begin
                                mismatch_next = 1'b1;
                            end
                            item_count_next = item_inc;
                            if (item_inc == field_length_reg) begin
                                phase_next = PH_ELEN;
                            end
                        end
                        PH_ELEN: begin
                            res_kind          = KIND_EXT_LEN;
                            field_length_next = field_value;
                            item_count_next   = '0;
                            phase_next        = (field_value != '0) ? PH_ECHR : PH_DLEN;
                        end
                        PH_ECHR: begin
                            res_kind        = KIND_EXT_CHR;
                            item_count_next = item_inc;
                            if (item_inc == field_length_reg) begin
                                phase_next = PH_DLEN;
                            end
                        end
                        PH_DLEN: begin
                            res_kind          = KIND_DATA_LEN;
                            field_length_next = field_value;
                            item_count_next   = '0;
                            if (field_value == '0) begin
                                phase_next = PH_DONE;
                                res_last   = 1'b1;
                            end else begin
                                phase_next = PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            res_kind        = KIND_DATA_BYTE;
                            item_count_next = item_inc;
                            if (item_inc == field_length_reg) begin
                                phase_next = PH_DONE;
                                res_last   = 1'b1;
                            end
                        end
                        default: begin
                            res_valid  = 1'b0;
                            phase_next = PH_DONE;
                        end
                    endcase
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_free) begin
            m_valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_MLEN;
            bit_count_reg    <= '0;
            item_count_reg   <= '0;
            field_length_reg <= '0;
            mismatch_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            bit_count_reg    <= bit_count_next;
            item_count_reg   <= item_count_next;
            field_length_reg <= field_length_next;
            mismatch_reg     <= mismatch_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (res_valid) begin
            m_kind_reg  <= res_kind;
            m_value_reg <= res_value;
            m_last_reg  <= res_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_kind  = m_kind_reg;
    assign m_value = m_value_reg;
    assign m_last  = m_last_reg;

endmodule
